// ----- sv/tpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle primitive assembler package
// Shared types, register indexes, mode codes and command codes.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [1:0] REG_PRIMITIVE_MODE  = 2'd0;
  localparam logic [1:0] REG_PRIMITIVE_COUNT = 2'd1;
  localparam logic [1:0] REG_VERTEX_COUNT    = 2'd2;

  localparam logic [2:0] MODE_TRI_LIST  = 3'd3;
  localparam logic [2:0] MODE_QUAD_LIST = 3'd4;
  localparam logic [2:0] MODE_TRI_STRIP = 3'd5;
  localparam logic [2:0] MODE_RESET     = MODE_TRI_LIST;

  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_HEADER = 1'b1;

  localparam logic OP_ONE_TRI = 1'b0;
  localparam logic OP_TWO_TRI = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [15:0] strip_length;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic signed [15:0] third_x;
    logic signed [15:0] third_y;
    logic signed [15:0] third_z;
    logic               last_of_run;
  } out_tri_t;

  typedef struct packed {
    logic we;
    logic [1:0] index;
    logic [15:0] data;
  } cfg_write_t;

endpackage

// ----- sv/triangle_primitive_assembler_core.sv -----
// ----------------------------------------------------------------------------
// Triangle primitive assembler core
// Builds triangles from a vertex stream in list, quad and strip modes.
// ----------------------------------------------------------------------------
// A triangle passes through the command queue and the result register, which holds it until pop.
// Throughput: one request per cycle while full is low; a quad's two triangles leave in turn from one command.
// The four-entry command queue sets how far the front and back may drift before full rises.
// Reset restores the register defaults and clears the mesh state and queues.
module triangle_primitive_assembler_core #(
  parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              push,
  output logic              full,
  input  tpa_pkg::in_item_t item,
  output logic              empty,
  input  logic              pop,
  output tpa_pkg::out_tri_t result
);

  localparam int CMD_W = 12 * COORD_BITS + 1;

  tpa_pkg::cfg_write_t cfg;
  logic                take;
  logic                cmd_valid;
  logic [CMD_W-1:0]    cmd_in;
  logic [CMD_W-1:0]    cmd_out;
  logic                cmd_empty;
  logic                cmd_pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign take      = push && !full;

  tpa_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .take     (take),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd      (cmd_in)
  );

  tpa_queue #(
    .WIDTH(CMD_W),
    .DEPTH(tpa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_valid),
    .wr_data(cmd_in),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_data(cmd_out),
    .empty  (cmd_empty)
  );

  tpa_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_out),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ----- sv/tpa_queue.sv -----
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module tpa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tpa_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- sv/tpa_front.sv -----
// ----------------------------------------------------------------------------
// Assembler front end
// Holds the configuration and the mesh state, classifies each request and
// queues a command for every request that completes one or two triangles.
// ----------------------------------------------------------------------------
module tpa_front #(
  parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tpa_pkg::cfg_write_t        cfg,
  input  logic                       take,
  input  tpa_pkg::in_item_t          item,
  output logic                       cmd_valid,
  output logic [12*COORD_BITS:0]     cmd
);

  localparam int VW = 3 * COORD_BITS;

  logic [2:0]    primitive_mode;
  logic [15:0]   primitive_count;
  logic [15:0]   vertex_count;

  logic [VW-1:0] older_vertex;
  logic [VW-1:0] middle_vertex;
  logic [VW-1:0] newest_vertex;
  logic [15:0]   position_in_primitive;
  logic [15:0]   strip_remaining;
  logic [15:0]   primitives_done;
  logic [15:0]   vertices_seen;

  logic [VW-1:0] older_vertex_next;
  logic [VW-1:0] middle_vertex_next;
  logic [VW-1:0] newest_vertex_next;
  logic [15:0]   position_in_primitive_next;
  logic [15:0]   strip_remaining_next;
  logic [15:0]   primitives_done_next;
  logic [15:0]   vertices_seen_next;

  logic [VW-1:0] vtx;
  logic          emit;
  logic          op;
  logic [VW-1:0] ca;
  logic [VW-1:0] cb;
  logic [VW-1:0] cc;
  logic [VW-1:0] cd;
  logic          room;
  logic          vertex_ok;

  assign vtx = {COORD_BITS'($unsigned(item.pos_z)),
                COORD_BITS'($unsigned(item.pos_y)),
                COORD_BITS'($unsigned(item.pos_x))};
  assign room      = (primitives_done < primitive_count);
  assign vertex_ok = (vertices_seen < vertex_count);

  always_comb begin
    older_vertex_next          = older_vertex;
    middle_vertex_next         = middle_vertex;
    newest_vertex_next         = newest_vertex;
    position_in_primitive_next = position_in_primitive;
    strip_remaining_next       = strip_remaining;
    primitives_done_next       = primitives_done;
    vertices_seen_next         = vertices_seen;
    emit = 1'b0;
    op   = tpa_pkg::OP_ONE_TRI;
    ca   = older_vertex;
    cb   = middle_vertex;
    cc   = vtx;
    cd   = vtx;
    if (item.req_type == tpa_pkg::REQ_HEADER) begin
      if (primitive_mode == tpa_pkg::MODE_TRI_STRIP && room) begin
        strip_remaining_next       = item.strip_length;
        position_in_primitive_next = '0;
        primitives_done_next       = primitives_done + 1'b1;
      end
    end else if (vertex_ok) begin
      case (primitive_mode)
        tpa_pkg::MODE_TRI_LIST, tpa_pkg::MODE_QUAD_LIST: begin
          if (room) begin
            vertices_seen_next = vertices_seen + 1'b1;
            if (position_in_primitive == 16'd0) begin
              older_vertex_next          = vtx;
              position_in_primitive_next = 16'd1;
            end else if (position_in_primitive == 16'd1) begin
              middle_vertex_next         = vtx;
              position_in_primitive_next = 16'd2;
            end else if (primitive_mode == tpa_pkg::MODE_TRI_LIST) begin
              newest_vertex_next         = vtx;
              position_in_primitive_next = '0;
              primitives_done_next       = primitives_done + 1'b1;
              emit = 1'b1;
            end else if (position_in_primitive == 16'd2) begin
              newest_vertex_next = vtx;
              if (vertices_seen_next >= vertex_count) begin
                position_in_primitive_next = '0;
                primitives_done_next       = primitives_done + 1'b1;
                emit = 1'b1;
              end else begin
                position_in_primitive_next = 16'd3;
              end
            end else begin
              position_in_primitive_next = '0;
              primitives_done_next       = primitives_done + 1'b1;
              emit = 1'b1;
              op   = tpa_pkg::OP_TWO_TRI;
              cc   = newest_vertex;
              cd   = vtx;
            end
          end
        end
        tpa_pkg::MODE_TRI_STRIP: begin
          if (strip_remaining != '0) begin
            strip_remaining_next = strip_remaining - 1'b1;
            vertices_seen_next   = vertices_seen + 1'b1;
            older_vertex_next    = middle_vertex;
            middle_vertex_next   = newest_vertex;
            newest_vertex_next   = vtx;
            if (position_in_primitive != 16'hFFFF) begin
              position_in_primitive_next = position_in_primitive + 1'b1;
            end
            if (position_in_primitive >= 16'd2) begin
              emit = 1'b1;
              if (position_in_primitive[0]) begin
                ca = newest_vertex;
                cb = middle_vertex;
              end else begin
                ca = middle_vertex;
                cb = newest_vertex;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_valid = take && emit;
  assign cmd       = {op, cd, cc, cb, ca};

  always_ff @(posedge clk) begin
    if (rst) begin
      primitive_mode        <= tpa_pkg::MODE_RESET;
      primitive_count       <= '0;
      vertex_count          <= '0;
      older_vertex          <= '0;
      middle_vertex         <= '0;
      newest_vertex         <= '0;
      position_in_primitive <= '0;
      strip_remaining       <= '0;
      primitives_done       <= '0;
      vertices_seen         <= '0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          tpa_pkg::REG_PRIMITIVE_MODE:  primitive_mode  <= cfg.data[2:0];
          tpa_pkg::REG_PRIMITIVE_COUNT: primitive_count <= cfg.data;
          tpa_pkg::REG_VERTEX_COUNT:    vertex_count    <= cfg.data;
          default: begin
          end
        endcase
      end
      if (take) begin
        older_vertex          <= older_vertex_next;
        middle_vertex         <= middle_vertex_next;
        newest_vertex         <= newest_vertex_next;
        position_in_primitive <= position_in_primitive_next;
        strip_remaining       <= strip_remaining_next;
        primitives_done       <= primitives_done_next;
        vertices_seen         <= vertices_seen_next;
      end
    end
  end

endmodule

// ----- sv/tpa_back.sv -----
// ----------------------------------------------------------------------------
// Assembler back end
// Expands queued commands into triangles and holds the waiting result.
// ----------------------------------------------------------------------------
module tpa_back #(
  parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_empty,
  input  logic [12*COORD_BITS:0] cmd,
  output logic                   cmd_pop,
  output logic                   empty,
  input  logic                   pop,
  output tpa_pkg::out_tri_t      result
);

  localparam int CB = COORD_BITS;
  localparam int VW = 3 * CB;

  logic          out_valid;
  logic          phase;
  logic          load;
  logic          op;
  logic [VW-1:0] ca;
  logic [VW-1:0] cb;
  logic [VW-1:0] cc;
  logic [VW-1:0] cd;
  logic [VW-1:0] v1;
  logic [VW-1:0] v2;
  logic          first_half;

  assign ca = cmd[VW-1:0];
  assign cb = cmd[2*VW-1:VW];
  assign cc = cmd[3*VW-1:2*VW];
  assign cd = cmd[4*VW-1:3*VW];
  assign op = cmd[4*VW];

  assign first_half = (op == tpa_pkg::OP_TWO_TRI) && !phase;
  assign v1         = phase ? cc : cb;
  assign v2         = phase ? cd : cc;
  assign load       = (!out_valid || pop) && !cmd_empty;
  assign cmd_pop    = load && !first_half;
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= first_half;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.first_x     <= tpa_pkg::FIELD_W'(ca[CB-1:0]);
      result.first_y     <= tpa_pkg::FIELD_W'(ca[2*CB-1:CB]);
      result.first_z     <= tpa_pkg::FIELD_W'(ca[3*CB-1:2*CB]);
      result.second_x    <= tpa_pkg::FIELD_W'(v1[CB-1:0]);
      result.second_y    <= tpa_pkg::FIELD_W'(v1[2*CB-1:CB]);
      result.second_z    <= tpa_pkg::FIELD_W'(v1[3*CB-1:2*CB]);
      result.third_x     <= tpa_pkg::FIELD_W'(v2[CB-1:0]);
      result.third_y     <= tpa_pkg::FIELD_W'(v2[2*CB-1:CB]);
      result.third_z     <= tpa_pkg::FIELD_W'(v2[3*CB-1:2*CB]);
      result.last_of_run <= !first_half;
    end
  end

endmodule
